// ===== rtl/lpg_pkg.sv =====
`default_nettype none

package lpg_pkg;

   // Coordinate width used unless the top level is given another one
   localparam int COORD_BITS_DEFAULT = 10;

   // Colour register
   localparam int                   COLOR_BITS       = 16;
   localparam logic [COLOR_BITS-1:0] DRAW_COLOR_RESET = 16'hFFF0;

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Width of one queued command: cmd, four coordinates, two spans,
   // two direction bits and the error term
   function automatic int entry_bits(input int coord_bits);
      entry_bits = 7 * coord_bits + 7;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lpg_req_if.sv =====
`default_nettype none

interface lpg_req_if
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] stop_x;
   logic [COORD_BITS-1:0] stop_y;

   modport source (
      output valid, cmd, start_x, start_y, stop_x, stop_y,
      input  ready
   );

   modport sink (
      input  valid, cmd, start_x, start_y, stop_x, stop_y,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/lpg_rsp_if.sv =====
`default_nettype none

interface lpg_rsp_if
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [COLOR_BITS-1:0] pixel_color;
   logic                  last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, last_pixel,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/lpg_front.sv =====
`default_nettype none

module lpg_front
   import lpg_pkg::*;
#(
   parameter  int COORD_BITS = COORD_BITS_DEFAULT,
   localparam int ENTRY_BITS = entry_bits(COORD_BITS)
) (
   lpg_req_if.sink               req_bus,
   output logic                  push_valid,
   input  wire                   push_ready,
   output logic [ENTRY_BITS-1:0] push_data
);

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic [COORD_BITS:0]   span_x;
      logic [COORD_BITS:0]   neg_span_y;
      logic                  x_goes_down;
      logic                  y_goes_down;
      logic [COORD_BITS+1:0] err_acc;
   } entry_type;

   entry_type             entry;
   logic [COORD_BITS-1:0] abs_dx;
   logic [COORD_BITS-1:0] abs_dy;

   // Absolute spans and step directions of the new line
   always_comb begin
      if (req_bus.stop_x >= req_bus.start_x) begin
         abs_dx = req_bus.stop_x - req_bus.start_x;
      end else begin
         abs_dx = req_bus.start_x - req_bus.stop_x;
      end
      if (req_bus.stop_y >= req_bus.start_y) begin
         abs_dy = req_bus.stop_y - req_bus.start_y;
      end else begin
         abs_dy = req_bus.start_y - req_bus.stop_y;
      end
   end

   // Build the queue entry; line set-up fields only matter for a start
   always_comb begin
      entry.cmd         = req_bus.cmd;
      entry.cur_x       = req_bus.start_x;
      entry.cur_y       = req_bus.start_y;
      entry.end_x       = req_bus.stop_x;
      entry.end_y       = req_bus.stop_y;
      entry.span_x      = {1'b0, abs_dx};
      entry.neg_span_y  = (COORD_BITS+1)'(0) - {1'b0, abs_dy};
      entry.x_goes_down = !(req_bus.start_x < req_bus.stop_x);
      entry.y_goes_down = !(req_bus.start_y < req_bus.stop_y);
      entry.err_acc     = {2'b00, abs_dx} - {2'b00, abs_dy};
   end

   assign push_valid    = req_bus.valid;
   assign push_data     = entry;
   assign req_bus.ready = push_ready;

endmodule

`default_nettype wire

// ===== rtl/lpg_queue.sv =====
`default_nettype none

module lpg_queue
   import lpg_pkg::*;
#(
   parameter int WIDTH = entry_bits(COORD_BITS_DEFAULT),
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push_valid,
   output logic             push_ready,
   input  wire [WIDTH-1:0]  push_data,
   output logic             pop_valid,
   input  wire              pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != COUNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lpg_back.sv =====
`default_nettype none

module lpg_back
   import lpg_pkg::*;
#(
   parameter  int COORD_BITS = COORD_BITS_DEFAULT,
   localparam int ENTRY_BITS = entry_bits(COORD_BITS)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   pop_valid,
   output logic                  pop_ready,
   input  wire  [ENTRY_BITS-1:0] pop_data,
   input  wire                   csr_write_en,
   input  wire  [COLOR_BITS-1:0] csr_write_data,
   lpg_rsp_if.source             rsp_bus
);

   localparam int ERR_BITS = COORD_BITS + 2;

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic [COORD_BITS:0]   span_x;
      logic [COORD_BITS:0]   neg_span_y;
      logic                  x_goes_down;
      logic                  y_goes_down;
      logic [ERR_BITS-1:0]   err_acc;
   } entry_type;

   entry_type entry;

   // Line state
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] end_x_ff, end_x_in;
   logic [COORD_BITS-1:0] end_y_ff, end_y_in;
   logic [COORD_BITS:0]   span_x_ff, span_x_in;
   logic [COORD_BITS:0]   neg_span_y_ff, neg_span_y_in;
   logic                  x_down_ff, x_down_in;
   logic                  y_down_ff, y_down_in;
   logic [ERR_BITS-1:0]   err_ff, err_in;
   logic                  active_ff, active_in;
   logic [COLOR_BITS-1:0] color_ff;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] pixel_x_ff;
   logic [COORD_BITS-1:0] pixel_y_ff;
   logic [COLOR_BITS-1:0] pixel_color_ff;
   logic                  last_ff;

   logic                     fire;
   logic                     emit;
   logic                     at_end;
   logic signed [ERR_BITS:0] twice;
   logic signed [ERR_BITS:0] span_ext;
   logic signed [ERR_BITS:0] neg_ext;
   logic signed [ERR_BITS:0] err_sum;
   logic                     move_x;
   logic                     move_y;

   assign entry     = pop_data;
   assign pop_ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire      = pop_valid && pop_ready;
   assign emit      = fire && (entry.cmd == CMD_STEP) && active_ff;
   assign at_end    = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);

   // Bresenham decision: twice the error against both spans
   always_comb begin
      twice    = $signed({err_ff, 1'b0});
      span_ext = $signed({{2{span_x_ff[COORD_BITS]}}, span_x_ff});
      neg_ext  = $signed({{2{neg_span_y_ff[COORD_BITS]}}, neg_span_y_ff});
      move_x   = twice > neg_ext;
      move_y   = twice < span_ext;
      err_sum  = $signed({err_ff[ERR_BITS-1], err_ff});
      if (move_x) begin
         err_sum = err_sum + neg_ext;
      end
      if (move_y) begin
         err_sum = err_sum + span_ext;
      end
   end

   // Next line state
   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      span_x_in     = span_x_ff;
      neg_span_y_in = neg_span_y_ff;
      x_down_in     = x_down_ff;
      y_down_in     = y_down_ff;
      err_in        = err_ff;
      active_in     = active_ff;
      if (fire) begin
         unique case (entry.cmd)
            CMD_START: begin
               cur_x_in      = entry.cur_x;
               cur_y_in      = entry.cur_y;
               end_x_in      = entry.end_x;
               end_y_in      = entry.end_y;
               span_x_in     = entry.span_x;
               neg_span_y_in = entry.neg_span_y;
               x_down_in     = entry.x_goes_down;
               y_down_in     = entry.y_goes_down;
               err_in        = entry.err_acc;
               active_in     = 1'b1;
            end
            CMD_STEP: begin
               if (active_ff) begin
                  if (at_end) begin
                     active_in = 1'b0;
                  end else begin
                     if (move_x) begin
                        cur_x_in = x_down_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
                     end
                     if (move_y) begin
                        cur_y_in = y_down_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
                     end
                     err_in = err_sum[ERR_BITS-1:0];
                  end
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         end_x_ff      <= '0;
         end_y_ff      <= '0;
         span_x_ff     <= '0;
         neg_span_y_ff <= '0;
         x_down_ff     <= 1'b0;
         y_down_ff     <= 1'b0;
         err_ff        <= '0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         color_ff      <= DRAW_COLOR_RESET;
      end else begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         end_x_ff      <= end_x_in;
         end_y_ff      <= end_y_in;
         span_x_ff     <= span_x_in;
         neg_span_y_ff <= neg_span_y_in;
         x_down_ff     <= x_down_in;
         y_down_ff     <= y_down_in;
         err_ff        <= err_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            color_ff <= csr_write_data;
         end
      end
   end

   // Pixel payload, loaded only when a pixel goes out
   always_ff @(posedge clock) begin
      if (emit) begin
         pixel_x_ff     <= cur_x_ff;
         pixel_y_ff     <= cur_y_ff;
         pixel_color_ff <= color_ff;
         last_ff        <= at_end;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_x     = pixel_x_ff;
   assign rsp_bus.pixel_y     = pixel_y_ff;
   assign rsp_bus.pixel_color = pixel_color_ff;
   assign rsp_bus.last_pixel  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/line_pixel_generator.sv =====
`default_nettype none

// Line pixel generator: Bresenham rasteriser for lines in every octant.
//
// req_bus (valid/ready): cmd = start loads the two endpoints and gives no
// pixel; cmd = step gives the next pixel of the current line. A step with
// no line in progress is dropped. A start during a line replaces it.
// rsp_bus (valid/ready): one pixel per accepted step, with pixel_x,
// pixel_y, the drawing colour and last_pixel set on the end point.
// csr_write_en/csr_write_data: drawing colour, to be written while idle.
//
// Throughput is one transaction per clock on each side while rsp_bus.ready
// is high. An accepted step is written into the two-entry command queue,
// and the stepper loads the output register as it leaves the queue. The
// stepper holds a transaction while the output register is full and
// rsp_bus.ready is low; the queue then fills and req_bus.ready drops.
// Reset clears the queue, the output register and the line state, and sets
// the colour to 0xFFF0.
module line_pixel_generator
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   lpg_req_if.sink               req_bus,
   lpg_rsp_if.source             rsp_bus,
   input  wire                   csr_write_en,
   input  wire  [COLOR_BITS-1:0] csr_write_data
);

   localparam int ENTRY_BITS = entry_bits(COORD_BITS);

   logic                  push_valid;
   logic                  push_ready;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ENTRY_BITS-1:0] pop_data;

   // Command decode and line set-up
   lpg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Command queue
   lpg_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Line stepper and output register
   lpg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_bus        (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== rtl/lpg_checker.sv =====
`default_nettype none

module lpg_checker
   import lpg_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input wire                  req_cmd,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire                  rsp_last,
   input wire [COLOR_BITS-1:0] rsp_color,
   input wire                  csr_write_en,
   input wire [COLOR_BITS-1:0] csr_write_data
);

   logic                  seen_start_ff;
   logic [COLOR_BITS-1:0] color_ff;

   // Shadow of the colour register and of whether any line was started
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_start_ff <= 1'b0;
         color_ff      <= DRAW_COLOR_RESET;
      end else begin
         if (req_valid && req_ready && (req_cmd == CMD_START)) begin
            seen_start_ff <= 1'b1;
         end
         if (csr_write_en) begin
            color_ff <= csr_write_data;
         end
      end
   end

   // Output register is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel valid after reset");

   // A stalled pixel holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last) && $stable(rsp_color))
      else $error("stalled pixel changed");

   // No pixel before any line was started
   a_no_line_no_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_start_ff)
      else $error("pixel without a started line");

   // Every pixel carries the programmed colour
   a_pixel_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_color == color_ff)
      else $error("pixel colour differs from register");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_cmd        (req_bus.cmd),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_last       (rsp_bus.last_pixel),
   .rsp_color      (rsp_bus.pixel_color),
   .csr_write_en   (csr_write_en),
   .csr_write_data (csr_write_data)
);

`default_nettype wire

// ===== verif/line_pixel_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the colour register port, runs its own line
// stepper on every accepted request and compares each accepted pixel with
// the oldest pixel it predicted.
module line_pixel_checker
   import lpg_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   lpg_req_if                    req_mon,
   lpg_rsp_if                    rsp_mon,
   input  wire                   csr_write_en,
   input  wire  [COLOR_BITS-1:0] csr_write_data,
   output int                    miss_count,
   output int                    pixels_pending,
   output int                    pixels_seen,
   output int                    lines_started
);

   localparam int CB = COORD_BITS_DEFAULT;

   typedef struct packed {
      logic [CB-1:0]         x;
      logic [CB-1:0]         y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_t;

   // Shadow of the line state
   logic [CB-1:0]         pen_x, pen_y, goal_x, goal_y;
   logic signed [CB:0]    run_x, neg_rise_y;
   logic                  x_back, y_back;
   logic signed [CB+1:0]  err_term;
   logic                  drawing;
   logic [COLOR_BITS-1:0] colour;

   pixel_t predicted_pixels[$];
   int     mismatches = 0;
   int     compared = 0;
   int     starts = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] pixel mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin : track
      int     dx, dy, twice, acc;
      pixel_t want, seen;
      if (reset) begin
         pen_x      = '0;
         pen_y      = '0;
         goal_x     = '0;
         goal_y     = '0;
         run_x      = '0;
         neg_rise_y = '0;
         x_back     = 1'b0;
         y_back     = 1'b0;
         err_term   = '0;
         drawing    = 1'b0;
         colour     = DRAW_COLOR_RESET;
         predicted_pixels.delete();
      end else begin
         // Result transaction against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.pixel_x, rsp_mon.pixel_y, rsp_mon.pixel_color,
                     rsp_mon.last_pixel};
            compared++;
            if (predicted_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel (%0d,%0d)", seen.x, seen.y));
            end else begin
               want = predicted_pixels.pop_front();
               compare_field("pixel_x", int'(seen.x), int'(want.x));
               compare_field("pixel_y", int'(seen.y), int'(want.y));
               compare_field("pixel_color", int'(seen.color), int'(want.color));
               compare_field("last_pixel", int'(seen.last), int'(want.last));
            end
         end

         if (csr_write_en)
            colour = csr_write_data;

         // Request transaction: load a line or advance the current one
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.cmd == CMD_START) begin
               pen_x  = req_mon.start_x;
               pen_y  = req_mon.start_y;
               goal_x = req_mon.stop_x;
               goal_y = req_mon.stop_y;
               dx = int'(req_mon.stop_x) - int'(req_mon.start_x);
               dy = int'(req_mon.stop_y) - int'(req_mon.start_y);
               if (dx < 0) dx = -dx;
               if (dy < 0) dy = -dy;
               run_x      = (CB+1)'(dx);
               neg_rise_y = (CB+1)'(-dy);
               x_back     = !(req_mon.start_x < req_mon.stop_x);
               y_back     = !(req_mon.start_y < req_mon.stop_y);
               err_term   = (CB+2)'(dx - dy);
               drawing    = 1'b1;
               starts++;
            end else if (drawing) begin
               want.x     = pen_x;
               want.y     = pen_y;
               want.color = colour;
               want.last  = (pen_x == goal_x) && (pen_y == goal_y);
               predicted_pixels.push_back(want);
               if (want.last) begin
                  drawing = 1'b0;
               end else begin
                  // Twice the error against both spans, strictly
                  twice = int'(err_term) * 2;
                  acc   = int'(err_term);
                  if (twice > int'(neg_rise_y)) begin
                     acc  += int'(neg_rise_y);
                     pen_x = x_back ? pen_x - 1'b1 : pen_x + 1'b1;
                  end
                  if (twice < int'(run_x)) begin
                     acc  += int'(run_x);
                     pen_y = y_back ? pen_y - 1'b1 : pen_y + 1'b1;
                  end
                  err_term = (CB+2)'(acc);
               end
            end
         end
      end
      miss_count     <= mismatches;
      pixels_pending <= predicted_pixels.size();
      pixels_seen    <= compared;
      lines_started  <= starts;
   end

endmodule

// ===== verif/line_pixel_generator_test.sv =====
`timescale 1ns / 1ps

module line_pixel_generator_test;
   import lpg_pkg::*;

   localparam int            CB            = COORD_BITS_DEFAULT;
   localparam logic [CB-1:0] CMAX          = '1;
   localparam int            LATENCY       = 4;
   localparam int            HOLD_CYCLES   = 300;
   localparam int            HOLD_PHASE    = 3;
   localparam int            COLOUR_PHASES = 7;
   localparam int            PHASE_ITEMS   = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [COLOR_BITS-1:0] csr_write_data = '0;

   lpg_req_if req_if ();
   lpg_rsp_if rsp_if ();

   int miss_count, pixels_pending, pixels_seen, lines_started;
   int phase_num = -1;
   bit no_idle = 1'b0;
   int offered = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   line_pixel_generator dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_if),
      .rsp_bus        (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   line_pixel_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .miss_count     (miss_count),
      .pixels_pending (pixels_pending),
      .pixels_seen    (pixels_seen),
      .lines_started  (lines_started)
   );

   // Watchdog
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // Pixel receiver: random back-pressure, one long hold-off in its phase
   initial begin : pixel_sink
      bit held = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && phase_num == HOLD_PHASE && !held) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 32);
         end
      end
   end

   function automatic logic [CB-1:0] rand_coord();
      return CB'($urandom_range(2 ** CB - 1));
   endfunction

   function automatic logic [CB-1:0] clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > int'(CMAX)) return CMAX;
      return CB'(v);
   endfunction

   // Pixels from start to stop inclusive
   function automatic int line_length(input logic [CB-1:0] x0, y0, x1, y1);
      int dx, dy;
      dx = int'(x1) - int'(x0);
      dy = int'(y1) - int'(y0);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (dx > dy ? dx : dy) + 1;
   endfunction

   // One request transaction, with random idle cycles ahead of it
   task automatic offer(input logic cmd, input logic [CB-1:0] sx, sy, ex, ey);
      while (!no_idle && $urandom_range(99) < 32) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cmd     <= cmd;
      req_if.start_x <= sx;
      req_if.start_y <= sy;
      req_if.stop_x  <= ex;
      req_if.stop_y  <= ey;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      offered++;
   endtask

   task automatic start_line(input logic [CB-1:0] x0, y0, x1, y1);
      offer(CMD_START, x0, y0, x1, y1);
   endtask

   // Step commands carry random coordinates, which the block ignores
   task automatic step_line(input int n);
      repeat (n) offer(CMD_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endtask

   // Stop sending until every predicted pixel has been seen
   task automatic wait_drained();
      int guard;
      req_if.valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pixels_pending != 0 && guard < 20000);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_colour(input logic [COLOR_BITS-1:0] v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Mostly complete lines, some abandoned or over-stepped, some noise
   task automatic random_lines(input int budget);
      int            done, pick, spread, len, steps, trim;
      logic [CB-1:0] x0, y0, x1, y1;
      done = 0;
      while (done < budget) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            offer(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord());
            done++;
         end else begin
            if (pick < 9) begin
               x0 = rand_coord();
               y0 = rand_coord();
               x1 = rand_coord();
               y1 = rand_coord();
            end else begin
               spread = (pick < 40) ? 40 : 10;
               x0 = ($urandom_range(9) == 0) ? ($urandom_range(1) ? CMAX : '0) : rand_coord();
               y0 = ($urandom_range(9) == 0) ? ($urandom_range(1) ? CMAX : '0) : rand_coord();
               x1 = clamp_coord(int'(x0) + int'($urandom_range(2 * spread)) - spread);
               y1 = clamp_coord(int'(y0) + int'($urandom_range(2 * spread)) - spread);
            end
            len   = line_length(x0, y0, x1, y1);
            steps = len;
            trim  = $urandom_range(9);
            if (trim == 0)
               steps = $urandom_range(len - 1);
            else if (trim == 1)
               steps = len + $urandom_range(3, 1);
            start_line(x0, y0, x1, y1);
            step_line(steps);
            done += 1 + steps;
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      logic [COLOR_BITS-1:0] colour;
      req_if.valid   <= 1'b0;
      req_if.cmd     <= CMD_START;
      req_if.start_x <= '0;
      req_if.start_y <= '0;
      req_if.stop_x  <= '0;
      req_if.stop_y  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed lines with the reset colour
      step_line(1);                          // step with no line in progress
      start_line('0, '0, '0, '0);            // single pixel, then an ignored step
      step_line(2);
      start_line(CMAX, '0, CMAX - CB'(2), CB'(3));     // steep, x falling
      step_line(4);
      start_line('0, CMAX, CB'(3), CMAX - CB'(1));     // shallow, y falling
      step_line(4);
      start_line(CB'(512), CB'(512), CMAX, CMAX);      // abandoned by the next start
      step_line(2);
      start_line(CMAX, CMAX, CMAX, CMAX - CB'(2));
      step_line(3);
      start_line(CMAX, CMAX, CMAX - CB'(1), CMAX - CB'(1));
      step_line(2);
      wait_drained();

      // Random lines, a new colour per phase
      for (int p = 0; p < COLOUR_PHASES; p++) begin
         colour = (p == 0) ? '0 : (p == 1) ? '1 : COLOR_BITS'($urandom);
         write_colour(colour);
         phase_num = p;
         no_idle   = (p == 1);
         random_lines(PHASE_ITEMS);
         wait_drained();
      end
      no_idle = 1'b0;
      repeat (10) @(posedge clock);

      $display("Run covered %0d request transactions over %0d colour settings,",
               offered, COLOUR_PHASES + 1);
      $display("with %0d lines started and %0d pixel transactions compared.",
               lines_started, pixels_seen);
      if (miss_count == 0 && pixels_pending == 0) begin
         $display("TB_OK");
      end else begin
         if (pixels_pending != 0)
            $display("%0d predicted pixels never arrived", pixels_pending);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
